/* rtl/mlfd_pkg.sv */
// Shared types and constants for the marker/length frame deframer.
package mlfd_pkg;

    // Default store sizes
    localparam int RX_BYTES_DEF  = 4096;
    localparam int OUT_BYTES_DEF = 4096;

    // Frame layout
    localparam int MARK_LEN  = 4;   // start word bytes, also end word bytes
    localparam int HDR_LEN   = 8;   // start word plus length field
    localparam int KEEP_TAIL = 3;   // bytes kept while no start word is seen
    localparam int FRAME_OVH = 12;  // header plus end word

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_WORD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_WORD   = 1'b1;

    // Item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_COPY,
        ST_RD,
        ST_FEED
    } mlfd_state_t;

endpackage

/* rtl/mlfd_if.sv */
// Channel interfaces: input items, result items and configuration writes.
interface mlfd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface mlfd_out_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic [7:0] frames_done;
    logic       bad_end_seen;
    logic       overflow_cleared;
    logic       frame_dropped;

    modport source (output valid, output out_valid, output out_byte, output out_last,
                    output frames_done, output bad_end_seen, output overflow_cleared,
                    output frame_dropped, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input out_last,
                    input frames_done, input bad_end_seen, input overflow_cleared,
                    input frame_dropped, output ready);
endinterface

interface mlfd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mlfd_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/marker_length_frame_deframer_unit.sv */
// Top level of the marker/length frame deframer: receive store, parser, output store.
//
//  channel | dir | transfer carries
//  --------+-----+-----------------------------------------------------------
//  item    | in  | kind, rx_byte
//  result  | out | out_valid, out_byte, out_last, frames_done, bad_end_seen,
//          |     | overflow_cleared, frame_dropped
//  cfg     | in  | index (0 start_word, 1 end_word), data
//
// One item at a time. A push that completes no frame and hits no bad end word
// is parsed in its accept cycle (result registered at that edge). A pop reads
// the output store and then loads the result in ST_POP. A good frame adds the
// copy of its payload through the receive store read port (ST_COPY) and then
// a closing ST_RD state; a bad end word replays the stored bytes, each read
// (ST_RD) and then parsed (ST_FEED), before the closing ST_RD. The first push
// after a start_word write replays the whole store the same way.
// Reset is asynchronous; stores need no clearing pass. A waiting result does
// not block a new transfer when it is taken in the same cycle.
module marker_length_frame_deframer_unit #(
    parameter int RX_BYTES  = mlfd_pkg::RX_BYTES_DEF,
    parameter int OUT_BYTES = mlfd_pkg::OUT_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mlfd_in_if.sink    item,
    mlfd_out_if.source result,
    mlfd_cfg_if.sink   cfg
);

    localparam int AW  = $clog2(RX_BYTES);
    localparam int CW  = $clog2(RX_BYTES + 1);
    localparam int OAW = $clog2(OUT_BYTES);
    localparam int OCW = $clog2(OUT_BYTES + 1);
    localparam logic [CW:0]    RX_LIM   = (CW+1)'(RX_BYTES);
    localparam logic [CW-1:0]  RX_FULL  = CW'(RX_BYTES);
    localparam logic [OCW-1:0] OUT_SIZE = OCW'(OUT_BYTES);
    localparam logic [OAW-1:0] OUT_TOP  = OAW'(OUT_BYTES - 1);

    // Circular add in the receive store
    function automatic logic [AW-1:0] rx_wrap(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
        if (s >= RX_LIM)
            s = s - RX_LIM;
        return s[AW-1:0];
    endfunction

    function automatic logic [OAW-1:0] out_inc(input logic [OAW-1:0] p);
        return (p == OUT_TOP) ? '0 : p + 1'b1;
    endfunction

    // Memories
    logic [7:0] rx_mem  [RX_BYTES];
    logic [8:0] out_mem [OUT_BYTES];
    logic [7:0] rx_rd_reg;
    logic [8:0] out_rd_reg;

    // Control and state registers
    mlfd_pkg::mlfd_state_t state_reg, state_next;
    logic [31:0]    start_word_reg, end_word_reg;
    logic           rescan_reg;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  avail_reg, avail_next;
    logic           started_reg, started_next;
    logic [31:0]    len_reg, len_next;
    logic [31:0]    last4_reg, last4_next;
    logic [OAW-1:0] ohead_reg, ohead_next;
    logic [OAW-1:0] otail_reg, otail_next;
    logic [OCW-1:0] ocount_reg, ocount_next;
    logic [AW-1:0]  cp_src_reg, cp_src_next;
    logic [OCW-1:0] cp_left_reg, cp_left_next;
    logic           cp_wr_reg, cp_wr_next;
    logic           cp_last_reg, cp_last_next;
    logic           pop_hit_reg, pop_hit_next;
    logic [7:0]     acc_done_reg, acc_done_next;
    logic           acc_bad_reg, acc_bad_next;
    logic           acc_drop_reg, acc_drop_next;
    logic           res_full_reg, res_full_next;
    logic           res_ov_reg, res_ov_next;
    logic [7:0]     res_byte_reg, res_byte_next;
    logic           res_last_reg, res_last_next;
    logic [7:0]     res_done_reg, res_done_next;
    logic           res_bad_reg, res_bad_next;
    logic           res_ovf_reg, res_ovf_next;
    logic           res_drop_reg, res_drop_next;

    // Memory port controls
    logic           rx_we, rx_re, pop_re;
    logic [AW-1:0]  rx_waddr, rx_raddr;

    logic accept;
    assign item.ready = (state_reg == mlfd_pkg::ST_IDLE) && (!res_full_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Byte parser: one stored byte enters the frame search
    logic [7:0]     fb;
    logic [CW-1:0]  f_base, cnt_inc, f_cnt, f_avail;
    logic [AW-1:0]  f_head, f_src;
    logic [31:0]    f_last4, f_len;
    logic           f_started, f_good, f_bad, f_drop;
    logic [OCW-1:0] free_sp;

    always_comb
    begin
        fb        = (state_reg == mlfd_pkg::ST_FEED) ? rx_rd_reg : item.rx_byte;
        f_base    = (state_reg == mlfd_pkg::ST_FEED) ? avail_reg : avail_reg + 1'b1;
        cnt_inc   = cnt_reg + 1'b1;
        f_last4   = {last4_reg[23:0], fb};
        free_sp   = OUT_SIZE - ocount_reg;
        f_started = started_reg;
        f_len     = len_reg;
        f_cnt     = cnt_inc;
        f_head    = head_reg;
        f_avail   = f_base;
        f_good    = 1'b0;
        f_bad     = 1'b0;
        f_drop    = 1'b0;
        f_src     = rx_wrap(head_reg, CW'(mlfd_pkg::HDR_LEN));
        if (!started_reg)
        begin
            if (cnt_inc == CW'(mlfd_pkg::MARK_LEN))
            begin
                if (f_last4 == start_word_reg)
                    f_started = 1'b1;
                else
                begin
                    f_head  = rx_wrap(head_reg, CW'(1));
                    f_avail = f_base - 1'b1;
                    f_cnt   = CW'(mlfd_pkg::KEEP_TAIL);
                end
            end
        end
        else
        begin
            if (cnt_inc > CW'(mlfd_pkg::MARK_LEN) && cnt_inc <= CW'(mlfd_pkg::HDR_LEN))
                f_len = {len_reg[23:0], fb};
            if (cnt_inc >= CW'(mlfd_pkg::FRAME_OVH) &&
                ({2'b00, len_reg} + 34'(mlfd_pkg::FRAME_OVH)) == 34'(cnt_inc))
            begin
                f_cnt     = '0;
                f_started = 1'b0;
                if (f_last4 == end_word_reg)
                begin
                    f_head  = rx_wrap(head_reg, cnt_inc);
                    f_avail = f_base - cnt_inc;
                    if (len_reg != 32'd0)
                    begin
                        if ({1'b0, len_reg} <= 33'(free_sp))
                            f_good = 1'b1;
                        else
                            f_drop = 1'b1;
                    end
                end
                else
                begin
                    f_bad   = 1'b1;
                    f_head  = rx_wrap(head_reg, CW'(mlfd_pkg::MARK_LEN));
                    f_avail = f_base - CW'(mlfd_pkg::MARK_LEN);
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlfd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == mlfd_pkg::KIND_POP)
                        state_next = mlfd_pkg::ST_POP;
                    else if (avail_reg < RX_FULL)
                    begin
                        if (rescan_reg)
                            state_next = mlfd_pkg::ST_RD;
                        else if (f_good)
                            state_next = mlfd_pkg::ST_COPY;
                        else if (f_bad)
                            state_next = mlfd_pkg::ST_RD;
                    end
                end
            end
            mlfd_pkg::ST_POP:  state_next = mlfd_pkg::ST_IDLE;
            mlfd_pkg::ST_COPY:
            begin
                if (cp_left_reg == '0)
                    state_next = mlfd_pkg::ST_RD;
            end
            mlfd_pkg::ST_RD:
            begin
                if (cnt_reg == avail_reg)
                    state_next = mlfd_pkg::ST_IDLE;
                else
                    state_next = mlfd_pkg::ST_FEED;
            end
            mlfd_pkg::ST_FEED:
            begin
                if (f_good)
                    state_next = mlfd_pkg::ST_COPY;
                else
                    state_next = mlfd_pkg::ST_RD;
            end
            default: state_next = mlfd_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result loading
    always_comb
    begin
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        avail_next    = avail_reg;
        started_next  = started_reg;
        len_next      = len_reg;
        last4_next    = last4_reg;
        ohead_next    = ohead_reg;
        otail_next    = cp_wr_reg ? out_inc(otail_reg) : otail_reg;
        ocount_next   = ocount_reg;
        cp_src_next   = cp_src_reg;
        cp_left_next  = cp_left_reg;
        cp_wr_next    = 1'b0;
        cp_last_next  = cp_last_reg;
        pop_hit_next  = pop_hit_reg;
        acc_done_next = acc_done_reg;
        acc_bad_next  = acc_bad_reg;
        acc_drop_next = acc_drop_reg;
        res_full_next = res_full_reg && !result.ready;
        res_ov_next   = res_ov_reg;
        res_byte_next = res_byte_reg;
        res_last_next = res_last_reg;
        res_done_next = res_done_reg;
        res_bad_next  = res_bad_reg;
        res_ovf_next  = res_ovf_reg;
        res_drop_next = res_drop_reg;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        pop_re        = 1'b0;
        rx_waddr      = rx_wrap(head_reg, avail_reg);
        rx_raddr      = rx_wrap(head_reg, cnt_reg);
        case (state_reg)
            mlfd_pkg::ST_IDLE:
            begin
                if (accept && item.kind == mlfd_pkg::KIND_POP)
                begin
                    pop_hit_next = (ocount_reg != '0);
                    if (ocount_reg != '0)
                    begin
                        pop_re      = 1'b1;
                        ohead_next  = out_inc(ohead_reg);
                        ocount_next = ocount_reg - 1'b1;
                    end
                end
                else if (accept && avail_reg >= RX_FULL)
                begin
                    // Receive overflow: drop everything stored
                    cnt_next      = '0;
                    avail_next    = '0;
                    started_next  = 1'b0;
                    res_full_next = 1'b1;
                    res_ov_next   = 1'b0;
                    res_byte_next = '0;
                    res_last_next = 1'b0;
                    res_done_next = '0;
                    res_bad_next  = 1'b0;
                    res_ovf_next  = 1'b1;
                    res_drop_next = 1'b0;
                end
                else if (accept && rescan_reg)
                begin
                    // Start word changed: store the byte, then search the store from its head
                    rx_we         = 1'b1;
                    cnt_next      = '0;
                    avail_next    = avail_reg + 1'b1;
                    started_next  = 1'b0;
                    acc_done_next = '0;
                    acc_bad_next  = 1'b0;
                    acc_drop_next = 1'b0;
                end
                else if (accept)
                begin
                    rx_we        = 1'b1;
                    head_next    = f_head;
                    cnt_next     = f_cnt;
                    avail_next   = f_avail;
                    started_next = f_started;
                    len_next     = f_len;
                    last4_next   = f_last4;
                    acc_done_next = {7'd0, f_good};
                    acc_bad_next  = f_bad;
                    acc_drop_next = f_drop;
                    if (f_good)
                    begin
                        ocount_next  = ocount_reg + len_reg[OCW-1:0];
                        cp_src_next  = f_src;
                        cp_left_next = len_reg[OCW-1:0];
                    end
                    else if (!f_bad)
                    begin
                        res_full_next = 1'b1;
                        res_ov_next   = 1'b0;
                        res_byte_next = '0;
                        res_last_next = 1'b0;
                        res_done_next = '0;
                        res_bad_next  = 1'b0;
                        res_ovf_next  = 1'b0;
                        res_drop_next = f_drop;
                    end
                end
            end
            mlfd_pkg::ST_POP:
            begin
                res_full_next = 1'b1;
                res_ov_next   = pop_hit_reg;
                res_byte_next = pop_hit_reg ? out_rd_reg[7:0] : 8'd0;
                res_last_next = pop_hit_reg && out_rd_reg[8];
                res_done_next = '0;
                res_bad_next  = 1'b0;
                res_ovf_next  = 1'b0;
                res_drop_next = 1'b0;
            end
            mlfd_pkg::ST_COPY:
            begin
                // Read one payload byte; it is written to the output store next cycle
                if (cp_left_reg != '0)
                begin
                    rx_re        = 1'b1;
                    rx_raddr     = cp_src_reg;
                    cp_src_next  = rx_wrap(cp_src_reg, CW'(1));
                    cp_left_next = cp_left_reg - 1'b1;
                    cp_wr_next   = 1'b1;
                    cp_last_next = (cp_left_reg == OCW'(1));
                end
            end
            mlfd_pkg::ST_RD:
            begin
                if (cnt_reg == avail_reg)
                begin
                    res_full_next = 1'b1;
                    res_ov_next   = 1'b0;
                    res_byte_next = '0;
                    res_last_next = 1'b0;
                    res_done_next = acc_done_reg;
                    res_bad_next  = acc_bad_reg;
                    res_ovf_next  = 1'b0;
                    res_drop_next = acc_drop_reg;
                end
                else
                    rx_re = 1'b1;
            end
            mlfd_pkg::ST_FEED:
            begin
                head_next     = f_head;
                cnt_next      = f_cnt;
                avail_next    = f_avail;
                started_next  = f_started;
                len_next      = f_len;
                last4_next    = f_last4;
                acc_bad_next  = acc_bad_reg | f_bad;
                acc_drop_next = acc_drop_reg | f_drop;
                if (f_good)
                begin
                    if (acc_done_reg != 8'hFF)
                        acc_done_next = acc_done_reg + 1'b1;
                    ocount_next  = ocount_reg + len_reg[OCW-1:0];
                    cp_src_next  = f_src;
                    cp_left_next = len_reg[OCW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Store ports
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rx_waddr] <= item.rx_byte;
        if (rx_re)
            rx_rd_reg <= rx_mem[rx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cp_wr_reg)
            out_mem[otail_reg] <= {cp_last_reg, rx_rd_reg};
        if (pop_re)
            out_rd_reg <= out_mem[ohead_reg];
    end

    // Configuration registers; a new start word forces a full search on the next push
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= '0;
            end_word_reg   <= '0;
            rescan_reg     <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                mlfd_pkg::REG_START_WORD:
                begin
                    start_word_reg <= cfg.data;
                    rescan_reg     <= 1'b1;
                end
                mlfd_pkg::REG_END_WORD:   end_word_reg   <= cfg.data;
                default: ;
            endcase
        end
        else if (accept && item.kind == mlfd_pkg::KIND_PUSH)
            rescan_reg <= 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mlfd_pkg::ST_IDLE;
            head_reg     <= '0;
            cnt_reg      <= '0;
            avail_reg    <= '0;
            started_reg  <= 1'b0;
            ohead_reg    <= '0;
            otail_reg    <= '0;
            ocount_reg   <= '0;
            cp_left_reg  <= '0;
            cp_wr_reg    <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            avail_reg    <= avail_next;
            started_reg  <= started_next;
            ohead_reg    <= ohead_next;
            otail_reg    <= otail_next;
            ocount_reg   <= ocount_next;
            cp_left_reg  <= cp_left_next;
            cp_wr_reg    <= cp_wr_next;
            res_full_reg <= res_full_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        last4_reg    <= last4_next;
        cp_src_reg   <= cp_src_next;
        cp_last_reg  <= cp_last_next;
        pop_hit_reg  <= pop_hit_next;
        acc_done_reg <= acc_done_next;
        acc_bad_reg  <= acc_bad_next;
        acc_drop_reg <= acc_drop_next;
        res_ov_reg   <= res_ov_next;
        res_byte_reg <= res_byte_next;
        res_last_reg <= res_last_next;
        res_done_reg <= res_done_next;
        res_bad_reg  <= res_bad_next;
        res_ovf_reg  <= res_ovf_next;
        res_drop_reg <= res_drop_next;
    end

    assign result.valid            = res_full_reg;
    assign result.out_valid        = res_ov_reg;
    assign result.out_byte         = res_byte_reg;
    assign result.out_last         = res_last_reg;
    assign result.frames_done      = res_done_reg;
    assign result.bad_end_seen     = res_bad_reg;
    assign result.overflow_cleared = res_ovf_reg;
    assign result.frame_dropped    = res_drop_reg;

endmodule

/* rtl/mlfd_chk.sv */
// Port-level checker for the deframer, bound to the top level.
module mlfd_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       o_valid,
    input logic       o_ready,
    input logic       o_out_valid,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic [7:0] o_frames_done,
    input logic       o_bad_end,
    input logic       o_overflow,
    input logic       o_dropped
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> o_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its bytes
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> $stable(o_out_byte) && $stable(o_frames_done))
        else $error("result payload changed while stalled");

    // A popped byte carries no push status
    a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_out_valid |->
            o_frames_done == 8'd0 && !o_bad_end && !o_overflow && !o_dropped)
        else $error("pop result carries push status");

    // Last mark and byte only with a popped byte
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_out_valid |-> !o_out_last && o_out_byte == 8'd0)
        else $error("byte fields set without a popped byte");

    // An overflow push parses nothing
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_overflow |-> o_frames_done == 8'd0 && !o_bad_end && !o_dropped)
        else $error("overflow push reports parse results");

endmodule

bind marker_length_frame_deframer_unit mlfd_chk u_mlfd_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .o_valid      (result.valid),
    .o_ready      (result.ready),
    .o_out_valid  (result.out_valid),
    .o_out_byte   (result.out_byte),
    .o_out_last   (result.out_last),
    .o_frames_done(result.frames_done),
    .o_bad_end    (result.bad_end_seen),
    .o_overflow   (result.overflow_cleared),
    .o_dropped    (result.frame_dropped)
);
